@@ rtl/core/sitbd_pkg.sv @@
// Shared types, constants and helpers for the signed integer to base digits block.
// No dependencies; compiled first.
package sitbd_pkg;

  localparam int DATA_W          = 32;
  localparam int CHAR_W          = 8;
  localparam int LEN_W           = 5;
  localparam int SYM_W           = 64;
  localparam int DIGIT_W         = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int MAX_DIGITS      = 32;
  localparam int NDIG_W          = $clog2(MAX_DIGITS);
  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CHAR_W-1:0] SIGN_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] SIGN_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] PRINT_LOW  = 8'd32;
  localparam logic [CHAR_W-1:0] PRINT_END  = 8'd127;
  localparam logic [LEN_W-1:0]  MIN_RADIX  = 5'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_LENGTH  = 2'd0,
    REG_SYMBOLS_LOW  = 2'd1,
    REG_SYMBOLS_HIGH = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [LEN_W-1:0] base_length;
    logic [SYM_W-1:0] symbols_low;
    logic [SYM_W-1:0] symbols_high;
  } cfg_t;

  typedef struct packed {
    logic              neg;
    logic [DATA_W-1:0] mag;
  } item_t;

  function automatic logic [CHAR_W-1:0] symbol_at(cfg_t c, logic [DIGIT_W-1:0] i);
    logic [SYM_W-1:0] w;
    w = i[3] ? c.symbols_high : c.symbols_low;
    return w[{i[2:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

@@ rtl/core/sitbd_if.sv @@
// Handshake channel interfaces: input value, output character, config write.
// Depends on sitbd_pkg.
interface sitbd_in_if import sitbd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sitbd_out_if import sitbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;
  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

interface sitbd_cfg_if import sitbd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SYM_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/sitbd_front.sv @@
// Front end: checks the symbol table, splits the value into sign and magnitude.
// Depends on sitbd_pkg and sitbd_if.
module sitbd_front import sitbd_pkg::*; #(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  cfg_t       cfg,
  sitbd_in_if.sink   din,
  input  logic       q_full,
  output logic       push_valid,
  output item_t      push_item,
  output logic       base_ok
);

  always_comb begin
    logic [CHAR_W-1:0] s;
    base_ok = (cfg.base_length >= MIN_RADIX) &&
              (cfg.base_length <= LEN_W'(MAX_SYMBOLS));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      s = symbol_at(cfg, DIGIT_W'(i));
      if (LEN_W'(i) < cfg.base_length) begin
        if (s < PRINT_LOW || s >= PRINT_END || s == SIGN_PLUS || s == SIGN_MINUS)
          base_ok = 1'b0;
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if (LEN_W'(j) < cfg.base_length && symbol_at(cfg, DIGIT_W'(j)) == s)
            base_ok = 1'b0;
        end
      end
    end
  end

  assign din.ready      = !q_full;
  assign push_valid     = din.valid && base_ok;
  assign push_item.neg  = din.value[DATA_W-1];
  assign push_item.mag  = din.value[DATA_W-1] ? (DATA_W'(0) - DATA_W'(din.value))
                                               : DATA_W'(din.value);

endmodule

@@ rtl/core/sitbd_queue.sv @@
// Short FIFO of classified words between front and back.
// Depends on sitbd_pkg.
module sitbd_queue import sitbd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  full,
  output logic  pop_valid,
  output item_t pop_item,
  input  logic  pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = entries[rd_ptr];
  assign push      = push_valid && !full;
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/sitbd_back.sv @@
// Back end: divides the magnitude by the radix 8 bits a cycle, then emits
// sign and digits most significant first. Depends on sitbd_pkg and sitbd_if.
module sitbd_back import sitbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_ready,
  sitbd_out_if.source dout
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SIGN, S_EMIT} state_t;

  state_t              state;
  logic [DATA_W-1:0]   w;
  logic [DIGIT_W-1:0]  rem;
  logic [1:0]          step;
  logic [NDIG_W-1:0]   nd;
  logic [NDIG_W-1:0]   k;
  logic                neg;
  logic [DIGIT_W-1:0]  digits [MAX_DIGITS];
  logic                out_valid;
  logic [CHAR_W-1:0]   out_char;
  logic                out_last;
  logic [DATA_W-1:0]   w_next;
  logic [DIGIT_W-1:0]  rem_next;
  logic                out_free;
  logic                out_load;

  // one byte of restoring division
  always_comb begin
    logic [LEN_W-1:0] r;
    logic [LEN_W-1:0] t;
    logic [7:0]       qb;
    r  = {1'b0, rem};
    qb = '0;
    for (int i = 0; i < 8; i++) begin
      t = {r[DIGIT_W-1:0], w[DATA_W-1-i]};
      if (t >= cfg.base_length) begin
        qb[7-i] = 1'b1;
        r = t - cfg.base_length;
      end else begin
        r = t;
      end
    end
    w_next   = {w[DATA_W-9:0], qb};
    rem_next = r[DIGIT_W-1:0];
  end

  assign out_free       = !out_valid || dout.ready;
  assign out_load       = out_free && (state == S_SIGN || state == S_EMIT);
  assign q_ready        = (state == S_IDLE);
  assign dout.valid     = out_valid;
  assign dout.character = out_char;
  assign dout.last      = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (dout.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            w     <= q_item.mag;
            neg   <= q_item.neg;
            rem   <= '0;
            step  <= '0;
            nd    <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          w    <= w_next;
          rem  <= (step == 2'd3) ? '0 : rem_next;
          step <= step + 1'b1;
          if (step == 2'd3) begin
            digits[nd] <= rem_next;
            nd         <= nd + 1'b1;
            if (w_next == '0 || nd == NDIG_W'(MAX_DIGITS - 1)) begin
              k     <= nd;
              state <= neg ? S_SIGN : S_EMIT;
            end
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_char  <= SIGN_MINUS;
            out_last  <= 1'b0;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_char  <= symbol_at(cfg, digits[k]);
            out_last  <= (k == '0);
            if (k == '0) state <= S_IDLE;
            else k <= k - 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/signed_integer_to_base_digits.sv @@
// Top level: config registers, front end, queue and back end.
// Depends on sitbd_pkg, sitbd_if, sitbd_front, sitbd_queue, sitbd_back.
//
// Usage:
//   cfg  : write channel (index, data); 0 base_length, 1 symbols_low,
//          2 symbols_high, other indexes ignored. Always ready. Write only
//          while the block is idle.
//   din  : one signed 32-bit value per word.
//   dout : one character per word, last set on the final one of a value.
// A value is dropped without output when the symbol table is invalid.
// A value leaves the queue into the divider, which finds its digits
// least significant first at 8 quotient bits per cycle; then the sign,
// if the value is negative, and the digits are output.
// The divider handles one value at a time; the queue holds QUEUE_DEPTH
// more, and din stalls when it is full.
// Reset clears the config registers (base invalid), the queue and the
// output register. A stalled dout holds its word; the back end waits,
// then the queue fills and din stalls.
module signed_integer_to_base_digits import sitbd_pkg::*; #(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sitbd_cfg_if.sink   cfg,
  sitbd_in_if.sink    din,
  sitbd_out_if.source dout
);

  cfg_t  cfg_regs;
  logic  push_valid;
  item_t push_item;
  logic  base_ok;
  logic  q_full;
  logic  q_valid;
  item_t q_item;
  logic  q_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      case (reg_index_t'(cfg.index))
        REG_BASE_LENGTH:  cfg_regs.base_length  <= cfg.data[LEN_W-1:0];
        REG_SYMBOLS_LOW:  cfg_regs.symbols_low  <= cfg.data;
        REG_SYMBOLS_HIGH: cfg_regs.symbols_high <= cfg.data;
        default: ;
      endcase
    end
  end

  sitbd_front #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_front (
    .cfg        (cfg_regs),
    .din        (din),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_item  (push_item),
    .base_ok    (base_ok)
  );

  sitbd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop_ready  (q_ready)
  );

  sitbd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready),
    .dout    (dout)
  );

`ifndef ASSERT_OFF
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !din.ready)
    else $error("input accepted while queue full");

  a_full_after_push: assert property (@(posedge clk) disable iff (rst)
    $rose(q_full) |-> $past(push_valid && din.ready && base_ok))
    else $error("queue filled without a push");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.character == SIGN_MINUS) |-> !dout.last)
    else $error("minus sign marked last");
`endif

endmodule

@@ verif/tb.sv @@
// Testbench for signed_integer_to_base_digits: directed and random values over many
// symbol tables, checked character by character against a local model of the conversion.
// Depends on sitbd_pkg, sitbd_if and the RTL of the block.
module tb;
  import sitbd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 600;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  typedef enum logic [1:0] {FLOW_OPEN, FLOW_RANDOM, FLOW_PATTERN} flow_t;

  logic clk;
  logic rst;

  sitbd_in_if  din();
  sitbd_out_if dout();
  sitbd_cfg_if cfg();

  signed_integer_to_base_digits dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .din  (din),
    .dout (dout)
  );

  cfg_t       table_cfg;
  text_char_t pending_text[$];
  text_char_t want;
  flow_t      flow;
  logic [7:0] stall_pattern;
  int         hold_ready;
  int         faults;
  int         values_sent;
  int         values_dropped;
  int         chars_checked;
  int         tables_loaded;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("tb: errors");
    $finish;
  end

  function automatic logic [CHAR_W-1:0] glyph(input int pos);
    if (pos < 8) return table_cfg.symbols_low[pos*8 +: CHAR_W];
    return table_cfg.symbols_high[(pos-8)*8 +: CHAR_W];
  endfunction

  function automatic bit table_ok();
    int n;
    int i;
    int j;
    logic [CHAR_W-1:0] c;
    n = int'(table_cfg.base_length);
    if (n < MIN_RADIX || n > MAX_SYMBOLS_DEF) return 1'b0;
    for (i = 0; i < n; i++) begin
      c = glyph(i);
      if (c < PRINT_LOW || c >= PRINT_END || c == SIGN_PLUS || c == SIGN_MINUS) return 1'b0;
      for (j = i + 1; j < n; j++)
        if (glyph(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // queues the text of one value; returns the number of characters
  function automatic int predict_text(input logic [DATA_W-1:0] raw);
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] radix;
    logic [DIGIT_W-1:0] digs[MAX_DIGITS];
    int nd;
    int k;
    text_char_t ch;
    if (!table_ok()) return 0;
    radix = DATA_W'(table_cfg.base_length);
    mag = raw[DATA_W-1] ? (~raw + 1'b1) : raw;
    nd = 0;
    do begin
      digs[nd] = DIGIT_W'(mag % radix);
      mag = mag / radix;
      nd++;
    end while (mag != 0 && nd < MAX_DIGITS);
    if (raw[DATA_W-1]) begin
      ch.character = SIGN_MINUS;
      ch.last = 1'b0;
      pending_text.push_back(ch);
    end
    for (k = nd - 1; k >= 0; k--) begin
      ch.character = glyph(digs[k]);
      ch.last = (k == 0);
      pending_text.push_back(ch);
    end
    return nd + raw[DATA_W-1];
  endfunction

  function automatic logic [127:0] pack_text(input string s);
    logic [127:0] r;
    int i;
    r = '0;
    for (i = 0; i < s.len() && i < 16; i++) r[8*i +: 8] = s[i];
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 40);
      1: v = 32'd0 - $urandom_range(1, 40);
      2: begin
        v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
        if ($urandom_range(0, 1)) v = 32'd0 - v;
      end
      3: begin
        case ($urandom_range(0, 3))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SYM_W-1:0] data);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do begin
      @(posedge clk);
    end while (cfg.ready !== 1'b1);
    case (idx)
      REG_BASE_LENGTH:  table_cfg.base_length  = data[LEN_W-1:0];
      REG_SYMBOLS_LOW:  table_cfg.symbols_low  = data;
      REG_SYMBOLS_HIGH: table_cfg.symbols_high = data;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic load_table(input logic [127:0] syms, input logic [SYM_W-1:0] len_word);
    write_reg(REG_BASE_LENGTH, len_word);
    write_reg(REG_SYMBOLS_LOW, syms[63:0]);
    write_reg(REG_SYMBOLS_HIGH, syms[127:64]);
    tables_loaded++;
  endtask

  task automatic load_random_table(input int len, input bit broken);
    logic [127:0] syms;
    logic [SYM_W-1:0] len_word;
    logic [CHAR_W-1:0] c;
    bit taken[256];
    int i;
    int a;
    int b;
    syms = {$urandom, $urandom, $urandom, $urandom};
    taken = '{default: 1'b0};
    for (i = 0; i < len; i++) begin
      do begin
        c = CHAR_W'($urandom_range(PRINT_LOW, PRINT_END - 1));
      end while (taken[c] || c == SIGN_PLUS || c == SIGN_MINUS);
      taken[c] = 1'b1;
      syms[8*i +: 8] = c;
    end
    if (broken) begin
      case ($urandom_range(0, 2))
        0: len = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
        1: begin
          case ($urandom_range(0, 3))
            0: c = CHAR_W'($urandom_range(0, PRINT_LOW - 1));
            1: c = CHAR_W'($urandom_range(PRINT_END, 255));
            2: c = SIGN_PLUS;
            default: c = SIGN_MINUS;
          endcase
          syms[8*$urandom_range(0, len - 1) +: 8] = c;
        end
        default: begin
          a = $urandom_range(0, len - 1);
          do b = $urandom_range(0, len - 1); while (b == a);
          syms[8*b +: 8] = syms[8*a +: 8];
        end
      endcase
    end
    len_word = {$urandom, $urandom};
    len_word[LEN_W-1:0] = LEN_W'(len);
    load_table(syms, len_word);
  endtask

  task automatic send_value(input logic [DATA_W-1:0] v);
    @(negedge clk);
    din.valid <= 1'b1;
    din.value <= v;
    do begin
      @(posedge clk);
    end while (din.ready !== 1'b1);
    if (predict_text(v) == 0) values_dropped++;
    values_sent++;
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      din.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic feed_values(input int count, input bit bursty);
    int burst_left;
    int n;
    burst_left = 0;
    for (n = 0; n < count; n++) begin
      if (bursty && burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        idle_gap($urandom_range(0, 6));
      end
      if (burst_left > 0) burst_left--;
      send_value(pick_value());
    end
  endtask

  task automatic drain();
    @(negedge clk);
    din.valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
  endtask

  // dropped values may still be in flight after the last character
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_flow(input flow_t f);
    flow = f;
    stall_pattern = 8'($urandom) | 8'h01;
  endtask

  task automatic test_reset_table();
    send_value(32'd123);
    send_value(32'hFFFF_FFFB);
    settle();
  endtask

  task automatic test_decimal();
    load_table(pack_text("0123456789"), 64'd10);
    send_value(32'd0);
    send_value(32'hFFFF_FFFF);
    send_value(32'd10);
    send_value(32'hFFFF_FFF6);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    settle();
  endtask

  task automatic test_binary();
    // symbols past the length are not checked
    load_table(pack_text("01+-"), 64'd2);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'hFFFF_FFFF);
    settle();
  endtask

  task automatic test_hex();
    load_table(pack_text(" 123456789abcde~"), 64'd16);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'h00AB_CDEF);
    settle();
  endtask

  task automatic bad_table(input logic [127:0] syms, input logic [SYM_W-1:0] len_word);
    load_table(syms, len_word);
    send_value(pick_value());
    settle();
  endtask

  task automatic test_bad_tables();
    logic [127:0] t;
    bad_table(pack_text("0"), 64'd1);
    bad_table(pack_text("0123456789abcdefg"), 64'd17);
    bad_table(pack_text("0123456789abcdef"), 64'd31);
    bad_table(pack_text("0+2"), 64'd3);
    bad_table(pack_text("-12"), 64'd3);
    t = pack_text("012");
    t[15:8] = PRINT_LOW - 8'd1;
    bad_table(t, 64'd3);
    t[15:8] = PRINT_END;
    bad_table(t, 64'd3);
    bad_table(pack_text("0120"), 64'd4);
    // spare index must leave the table alone
    load_table(pack_text("01234567"), 64'd8);
    write_reg(REG_SPARE, 64'd3);
    send_value(32'd100);
    settle();
  endtask

  task automatic test_random_tables();
    int p;
    int len;
    bit broken;
    for (p = 0; p < 10; p++) begin
      broken = (p % 5 == 4);
      len = (p == 0) ? 2 : (p == 1) ? 16 : $urandom_range(2, 16);
      load_random_table(len, broken);
      set_flow((p == 2) ? FLOW_OPEN : flow_t'($urandom_range(0, 2)));
      feed_values(broken ? 6 : 24, p != 2);
      settle();
    end
  endtask

  task automatic test_backpressure();
    load_table(pack_text("0123456789"), 64'd10);
    set_flow(FLOW_OPEN);
    hold_ready = 300;
    feed_values(10, 1'b0);
    drain();
    set_flow(FLOW_RANDOM);
    feed_values(8, 1'b1);
    settle();
  endtask

  initial begin
    dout.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ready > 0) begin
        dout.ready <= 1'b0;
        hold_ready--;
      end else begin
        case (flow)
          FLOW_RANDOM: dout.ready <= ($urandom_range(0, 3) != 0);
          FLOW_PATTERN: begin
            dout.ready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
          end
          default: dout.ready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && dout.valid === 1'b1 && dout.ready === 1'b1) begin
      if (pending_text.size() == 0) begin
        $error("unexpected word: character %h last %b", dout.character, dout.last);
        faults++;
      end else begin
        want = pending_text.pop_front();
        chars_checked++;
        if (dout.character !== want.character) begin
          $error("character: expected %h, got %h", want.character, dout.character);
          faults++;
        end
        if (dout.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, dout.last);
          faults++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    din.valid = 1'b0;
    din.value = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    table_cfg = '0;
    hold_ready = 0;
    faults = 0;
    values_sent = 0;
    values_dropped = 0;
    chars_checked = 0;
    tables_loaded = 0;
    set_flow(FLOW_OPEN);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_table();
    test_decimal();
    test_binary();
    test_hex();
    test_bad_tables();
    set_flow(FLOW_PATTERN);
    test_backpressure();
    test_random_tables();

    settle();
    $display("tb: %0d values over %0d symbol tables, %0d dropped on invalid tables",
             values_sent, tables_loaded, values_dropped);
    $display("tb: %0d characters compared", chars_checked);
    if (faults == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
